FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the swept box collision core
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: rtl/sbc_pkg.sv
// ---------------------------------------------------------------------------
// sbc_pkg: shared types and constants
// Widths of coordinates, times and the per-item work word between stages.
// ---------------------------------------------------------------------------
package sbc_pkg;
   localparam int COORD_W = 24;
   localparam int TIME_FRAC_BITS = 16;
   localparam int HIT_TIME_W = 17;
   localparam int DIST_W = 26;   // edge differences
   localparam int DEL_W = 25;    // |delta|
   localparam int DIV_STEPS = TIME_FRAC_BITS + 1; // quotient bits needed
   localparam int QUO_W = DIV_STEPS;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIST_W-1:0] dist_type;
   typedef logic [DEL_W-1:0] del_type;

   // result of the compare stages, travels beside the divider
   typedef struct packed {
      logic hit;
      logic use_x;
      logic neg_dir;
   } verdict_type;
endpackage

FILE: rtl/swept_box_collision_core.sv
// ---------------------------------------------------------------------------
// swept_box_collision_core: swept 2D box collision, fixed point
// Broad phase, exact ratio compares and a pipelined entry time divider.
// ---------------------------------------------------------------------------
// Pipeline from accepted request word to response register: 3 setup/compare
// stages, 18 divider stages, 1 output stage.
// Throughput: one word per cycle; the whole pipe holds on rsp_stall.
// Reset: synchronous, clears all stage valid bits; payload is not reset.
module swept_box_collision_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  sbc_pkg::coord_type req_move_left,
   input  sbc_pkg::coord_type req_move_top,
   input  sbc_pkg::coord_type req_move_right,
   input  sbc_pkg::coord_type req_move_bottom,
   input  sbc_pkg::coord_type req_delta_x,
   input  sbc_pkg::coord_type req_delta_y,
   input  sbc_pkg::coord_type req_still_left,
   input  sbc_pkg::coord_type req_still_top,
   input  sbc_pkg::coord_type req_still_right,
   input  sbc_pkg::coord_type req_still_bottom,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_hit,
   output logic [sbc_pkg::HIT_TIME_W-1:0] rsp_hit_time,
   output logic signed [1:0] rsp_normal_x,
   output logic signed [1:0] rsp_normal_y
);
   import sbc_pkg::*;
   `include "assert_macros.svh"

   // advance the whole pipe unless a finished word sits stalled at the output
   logic advance;
   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   logic f_valid;
   verdict_type f_verdict;
   dist_type f_num;
   del_type f_den;

   sbc_front u_front (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid),
      .ml(req_move_left), .mt(req_move_top), .mr(req_move_right),
      .mb(req_move_bottom), .dx(req_delta_x), .dy(req_delta_y),
      .sl(req_still_left), .st(req_still_top), .sr(req_still_right),
      .sb(req_still_bottom),
      .out_valid(f_valid), .verdict(f_verdict), .num(f_num), .den(f_den)
   );

   logic d_valid;
   verdict_type d_verdict;
   logic [QUO_W-1:0] d_quo;

   sbc_divider u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(f_valid), .in_verdict(f_verdict), .num(f_num), .den(f_den),
      .out_valid(d_valid), .out_verdict(d_verdict), .quotient(d_quo)
   );

   // place the normal on the entering axis; zero on a miss
   logic signed [1:0] normal_x_in, normal_y_in;
   always_comb begin
      normal_x_in = 2'sd0;
      normal_y_in = 2'sd0;
      if (d_verdict.hit) begin
         if (d_verdict.use_x) normal_x_in = d_verdict.neg_dir ? -2'sd1 : 2'sd1;
         else normal_y_in = d_verdict.neg_dir ? -2'sd1 : 2'sd1;
      end
   end

   // output register: zero the payload on a miss
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (advance) begin
         rsp_valid <= d_valid;
      end
      if (advance) begin
         rsp_hit <= d_verdict.hit;
         rsp_hit_time <= d_verdict.hit ? HIT_TIME_W'(d_quo) : '0;
         rsp_normal_x <= normal_x_in;
         rsp_normal_y <= normal_y_in;
      end
   end

   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_hit_time == '0 && rsp_normal_x == 2'sd0 && rsp_normal_y == 2'sd0)
   `ASSERT_IMPLIES(a_one_normal, clock, reset, rsp_valid && rsp_hit,
      (rsp_normal_x == 2'sd0) != (rsp_normal_y == 2'sd0))
   `ASSERT_IMPLIES(a_time_range, clock, reset, rsp_valid && rsp_hit,
      rsp_hit_time <= HIT_TIME_W'(1 << TIME_FRAC_BITS))
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_hit_time) && $stable(rsp_hit))
endmodule

FILE: rtl/sbc_front.sv
// ---------------------------------------------------------------------------
// sbc_front: broad phase and axis setup
// Register stages: edge sums and differences, products of the exact ratio
// compares, then the axis choice. Emits the verdict and division operands.
// ---------------------------------------------------------------------------
module sbc_front (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  sbc_pkg::coord_type ml, mt, mr, mb, dx, dy, sl, st, sr, sb,
   output logic out_valid,
   output sbc_pkg::verdict_type verdict,
   output sbc_pkg::dist_type num,
   output sbc_pkg::del_type den
);
   import sbc_pkg::*;

   // stage A registers
   logic a_valid_ff;
   logic a_miss_ff;
   logic ax_still_ff, ay_still_ff, dx_pos_ff, dy_pos_ff;
   dist_type ax_en_ff, ax_ex_ff, ay_en_ff, ay_ex_ff;
   del_type ax_d_ff, ay_d_ff;

   dist_type bl, bt, br, bb;
   dist_type ax_en_in, ax_ex_in, ay_en_in, ay_ex_in;
   del_type ax_d_in, ay_d_in;
   logic miss_in;

   always_comb begin
      bl = (dx > 0) ? DIST_W'(ml) : DIST_W'(ml) + DIST_W'(dx);
      bt = (dy > 0) ? DIST_W'(mt) : DIST_W'(mt) + DIST_W'(dy);
      br = (dx > 0) ? DIST_W'(mr) + DIST_W'(dx) : DIST_W'(mr);
      bb = (dy > 0) ? DIST_W'(mb) + DIST_W'(dy) : DIST_W'(mb);
      miss_in = (br < DIST_W'(sl)) || (bl > DIST_W'(sr)) ||
                (bb < DIST_W'(st)) || (bt > DIST_W'(sb));
      if (dx > 0) begin
         ax_en_in = DIST_W'(sl) - DIST_W'(mr);
         ax_ex_in = DIST_W'(sr) - DIST_W'(ml);
         ax_d_in = DEL_W'(dx);
      end else begin
         ax_en_in = DIST_W'(ml) - DIST_W'(sr);
         ax_ex_in = DIST_W'(mr) - DIST_W'(sl);
         ax_d_in = DEL_W'(-DIST_W'(dx));
      end
      if (dy > 0) begin
         ay_en_in = DIST_W'(st) - DIST_W'(mb);
         ay_ex_in = DIST_W'(sb) - DIST_W'(mt);
         ay_d_in = DEL_W'(dy);
      end else begin
         ay_en_in = DIST_W'(mt) - DIST_W'(sb);
         ay_ex_in = DIST_W'(mb) - DIST_W'(st);
         ay_d_in = DEL_W'(-DIST_W'(dy));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
      end
      if (advance) begin
         a_miss_ff <= miss_in;
         ax_still_ff <= (dx == 0);
         ay_still_ff <= (dy == 0);
         dx_pos_ff <= (dx > 0);
         dy_pos_ff <= (dy > 0);
         ax_en_ff <= ax_en_in;
         ax_ex_ff <= ax_ex_in;
         ay_en_ff <= ay_en_in;
         ay_ex_ff <= ay_ex_in;
         ax_d_ff <= ax_d_in;
         ay_d_ff <= ay_d_in;
      end
   end

   // stage B: cross products, one per 26x25 multiplier
   localparam int PROD_W = DIST_W + DEL_W + 1;
   typedef logic signed [PROD_W-1:0] prod_type;
   logic b_valid_ff, b_early_miss_ff;
   logic bx_still_ff, by_still_ff, bdx_pos_ff, bdy_pos_ff;
   prod_type p_xy_ff, p_yx_ff;      // ax.en*ay.d , ay.en*ax.d
   prod_type p_xex_x_ff, p_xex_y_ff; // ax.ex*ay.d , ay.ex*ax.d
   dist_type bx_en_ff, by_en_ff, bx_ex_ff, by_ex_ff;
   del_type bx_d_ff, by_d_ff;
   logic early_miss_in;

   always_comb begin
      early_miss_in = a_miss_ff || (ax_still_ff && ay_still_ff) ||
         ((ax_still_ff || ax_en_ff < 0) && (ay_still_ff || ay_en_ff < 0)) ||
         (!ax_still_ff && ax_en_ff > $signed({1'b0, ax_d_ff})) ||
         (!ay_still_ff && ay_en_ff > $signed({1'b0, ay_d_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         b_early_miss_ff <= early_miss_in;
         bx_still_ff <= ax_still_ff;
         by_still_ff <= ay_still_ff;
         bdx_pos_ff <= dx_pos_ff;
         bdy_pos_ff <= dy_pos_ff;
         p_xy_ff <= PROD_W'(ax_en_ff) * PROD_W'($signed({1'b0, ay_d_ff}));
         p_yx_ff <= PROD_W'(ay_en_ff) * PROD_W'($signed({1'b0, ax_d_ff}));
         p_xex_x_ff <= PROD_W'(ax_ex_ff) * PROD_W'($signed({1'b0, ay_d_ff}));
         p_xex_y_ff <= PROD_W'(ay_ex_ff) * PROD_W'($signed({1'b0, ax_d_ff}));
         bx_en_ff <= ax_en_ff;
         by_en_ff <= ay_en_ff;
         bx_ex_ff <= ax_ex_ff;
         by_ex_ff <= ay_ex_ff;
         bx_d_ff <= ax_d_ff;
         by_d_ff <= ay_d_ff;
      end
   end

   // stage C: choose the entering axis and check exits against it
   logic use_x, exit_miss;
   always_comb begin
      if (bx_still_ff) use_x = 1'b0;
      else if (by_still_ff) use_x = 1'b1;
      else use_x = (p_xy_ff > p_yx_ff);
      // within one axis, en > ex compares without products
      exit_miss = 1'b0;
      if (use_x) begin
         if (bx_en_ff > bx_ex_ff) exit_miss = 1'b1;
         if (!by_still_ff && (p_xy_ff > p_xex_y_ff)) exit_miss = 1'b1;
      end else begin
         if (by_en_ff > by_ex_ff) exit_miss = 1'b1;
         if (!bx_still_ff && (p_yx_ff > p_xex_x_ff)) exit_miss = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (advance) begin
         out_valid <= b_valid_ff;
      end
      if (advance) begin
         verdict.hit <= !(b_early_miss_ff || exit_miss);
         verdict.use_x <= use_x;
         verdict.neg_dir <= use_x ? bdx_pos_ff : bdy_pos_ff;
         num <= use_x ? bx_en_ff : by_en_ff;
         den <= use_x ? bx_d_ff : by_d_ff;
      end
   end
endmodule

FILE: rtl/sbc_divider.sv
// ---------------------------------------------------------------------------
// sbc_divider: pipelined restoring divider
// One quotient bit per stage; computes (num << TIME_FRAC_BITS) / den where
// num <= den, so the quotient fits HIT_TIME_W bits. Verdict rides along.
// ---------------------------------------------------------------------------
module sbc_divider (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  sbc_pkg::verdict_type in_verdict,
   input  sbc_pkg::dist_type num,
   input  sbc_pkg::del_type den,
   output logic out_valid,
   output sbc_pkg::verdict_type out_verdict,
   output logic [sbc_pkg::QUO_W-1:0] quotient
);
   import sbc_pkg::*;

   localparam int REM_W = DEL_W + 1;

   logic [DIV_STEPS:0] valid_ff;
   verdict_type verdict_ff [DIV_STEPS+1];
   logic [REM_W-1:0] rem_ff [DIV_STEPS+1];
   del_type den_ff [DIV_STEPS+1];
   logic [QUO_W-1:0] quo_ff [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
      if (advance) begin
         verdict_ff[0] <= in_verdict;
         // a hit guarantees 0 <= num <= den; clamp otherwise (unused)
         rem_ff[0] <= in_verdict.hit ? REM_W'(unsigned'(num)) : '0;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
      end
   end

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [REM_W:0] trial;
      logic [REM_W:0] shifted;
      always_comb begin
         shifted = (s == 0) ? {1'b0, rem_ff[s]} : {rem_ff[s], 1'b0};
         trial = shifted - {2'b00, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (advance) begin
            verdict_ff[s+1] <= verdict_ff[s];
            den_ff[s+1] <= den_ff[s];
            if (!trial[REM_W]) begin
               rem_ff[s+1] <= trial[REM_W-1:0];
               quo_ff[s+1] <= {quo_ff[s][QUO_W-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= shifted[REM_W-1:0];
               quo_ff[s+1] <= {quo_ff[s][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS];
   assign out_verdict = verdict_ff[DIV_STEPS];
   assign quotient = quo_ff[DIV_STEPS];
endmodule
